>>> src/dpp_pkg.sv
// shared types and constants for the depth pixel to point block
`default_nettype none

package dpp_pkg;

    localparam int PIX_W   = 8;
    localparam int CTR_W   = 14;
    localparam int INV_W   = 24;
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 24;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    // register map, one word apart
    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_INV_FOCAL_X,
        REG_INV_FOCAL_Y,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_COLOR_ENABLE
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] depth;
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
    } pix_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [PIX_W-1:0]          point_z;
        logic [PIX_W-1:0]          blue_out;
        logic [PIX_W-1:0]          green_out;
        logic [PIX_W-1:0]          red_out;
        logic                      point_valid;
        logic                      frame_last;
    } pt_t;

    typedef struct packed {
        logic [CTR_W-1:0]  center_x;
        logic [CTR_W-1:0]  center_y;
        logic [INV_W-1:0]  inv_focal_x;
        logic [INV_W-1:0]  inv_focal_y;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
        logic              color_enable;
    } cfg_t;

    // datapath commands from the controller
    typedef struct packed {
        logic capture;
        logic mul_depth;
        logic mul_focal;
        logic load_out;
    } cmd_t;

endpackage

`default_nettype wire

>>> src/dpp_cfg.sv
// configuration register bank behind the apb port
`default_nettype none

module dpp_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [dpp_pkg::DATA_W-1:0]  pwdata,
    output logic      [dpp_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output dpp_pkg::cfg_t                    cfg
);

    dpp_pkg::cfg_t     cfg_reg;
    dpp_pkg::cfg_t     cfg_next;
    dpp_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = dpp_pkg::reg_idx_t'(paddr[dpp_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                dpp_pkg::REG_CENTER_X:     cfg_next.center_x = pwdata[dpp_pkg::CTR_W-1:0];
                dpp_pkg::REG_CENTER_Y:     cfg_next.center_y = pwdata[dpp_pkg::CTR_W-1:0];
                dpp_pkg::REG_INV_FOCAL_X:  cfg_next.inv_focal_x = pwdata[dpp_pkg::INV_W-1:0];
                dpp_pkg::REG_INV_FOCAL_Y:  cfg_next.inv_focal_y = pwdata[dpp_pkg::INV_W-1:0];
                dpp_pkg::REG_FRAME_WIDTH:  cfg_next.frame_width = pwdata[dpp_pkg::SIZE_W-1:0];
                dpp_pkg::REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[dpp_pkg::SIZE_W-1:0];
                dpp_pkg::REG_COLOR_ENABLE: cfg_next.color_enable = pwdata[0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dpp_pkg::REG_CENTER_X:     prdata = dpp_pkg::DATA_W'(cfg_reg.center_x);
            dpp_pkg::REG_CENTER_Y:     prdata = dpp_pkg::DATA_W'(cfg_reg.center_y);
            dpp_pkg::REG_INV_FOCAL_X:  prdata = dpp_pkg::DATA_W'(cfg_reg.inv_focal_x);
            dpp_pkg::REG_INV_FOCAL_Y:  prdata = dpp_pkg::DATA_W'(cfg_reg.inv_focal_y);
            dpp_pkg::REG_FRAME_WIDTH:  prdata = dpp_pkg::DATA_W'(cfg_reg.frame_width);
            dpp_pkg::REG_FRAME_HEIGHT: prdata = dpp_pkg::DATA_W'(cfg_reg.frame_height);
            dpp_pkg::REG_COLOR_ENABLE: prdata = dpp_pkg::DATA_W'(cfg_reg.color_enable);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x     <= 14'd4976;
            cfg_reg.center_y     <= 14'd3904;
            cfg_reg.inv_focal_x  <= 24'd28292;
            cfg_reg.inv_focal_y  <= 24'd28532;
            cfg_reg.frame_width  <= 11'd640;
            cfg_reg.frame_height <= 11'd480;
            cfg_reg.color_enable <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> src/dpp_ctrl.sv
// sequencing controller: capture, two multiply steps, output load
`default_nettype none

module dpp_ctrl (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pix_valid,
    output logic         pix_ready,
    output logic         pt_valid,
    input  wire logic    pt_ready,
    output dpp_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_DEPTH,
        S_MUL_FOCAL,
        S_SATURATE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   pt_valid_reg;
    logic   pt_valid_next;
    logic   out_free;

    assign pix_ready = (state_reg == S_IDLE);
    assign pt_valid  = pt_valid_reg;
    // the output register can take a new point when empty or being drained
    assign out_free  = !pt_valid_reg || pt_ready;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        pt_valid_next = pt_valid_reg;
        if (pt_valid_reg && pt_ready)
        begin
            pt_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL_DEPTH;
                end
            end
            S_MUL_DEPTH:
            begin
                cmd.mul_depth = 1'b1;
                state_next    = S_MUL_FOCAL;
            end
            S_MUL_FOCAL:
            begin
                cmd.mul_focal = 1'b1;
                state_next    = S_SATURATE;
            end
            S_SATURATE:
            begin
                if (out_free)
                begin
                    cmd.load_out  = 1'b1;
                    pt_valid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pt_valid_reg <= pt_valid_next;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!pt_valid_reg || pt_ready))
        else $error("output overwritten while a point is still held");

    a_request_to_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |-> ##3 (state_reg == S_SATURATE))
        else $error("request did not reach the saturate step in time");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> pt_valid_reg)
        else $error("loaded point not presented");

    a_valid_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pt_valid_reg) |-> ($past(state_reg) == S_SATURATE))
        else $error("point presented without a finished computation");

endmodule

`default_nettype wire

>>> src/dpp_datapath.sv
// raster counters, offset, multiply, round and saturate, output register
`default_nettype none

module dpp_datapath #(
    parameter int MAX_DIM       = 1024,
    parameter int OUT_FRAC_BITS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dpp_pkg::cfg_t cfg,
    input  wire dpp_pkg::cmd_t cmd,
    input  wire dpp_pkg::pix_t pix,
    output dpp_pkg::pt_t       pt
);

    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int SZ_W   = (CNT_W + 1 > dpp_pkg::SIZE_W) ? CNT_W + 1 : dpp_pkg::SIZE_W;
    localparam int OFF_W  = ((CNT_W + 4 > dpp_pkg::CTR_W) ? CNT_W + 4 : dpp_pkg::CTR_W) + 1;
    localparam int MAG_W  = OFF_W - 1;
    localparam int PZ_W   = MAG_W + dpp_pkg::PIX_W;
    localparam int PROD_W = PZ_W + dpp_pkg::INV_W;
    localparam int SH     = 28 - OUT_FRAC_BITS;
    localparam logic [PROD_W:0] HALF    = (PROD_W + 1)'(1) << (SH - 1);
    localparam logic [PROD_W:0] LIM_POS = (PROD_W + 1)'(8388607);
    localparam logic [PROD_W:0] LIM_NEG = (PROD_W + 1)'(8388608);

    // raster position
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    logic [SZ_W-1:0]  width_eff;
    logic [SZ_W-1:0]  height_eff;
    logic             end_row;
    logic             end_col_row;

    logic signed [OFF_W-1:0] dx;
    logic signed [OFF_W-1:0] dy;

    // captured pixel
    logic [dpp_pkg::PIX_W-1:0] z_reg;
    logic [dpp_pkg::PIX_W-1:0] blue_reg;
    logic [dpp_pkg::PIX_W-1:0] green_reg;
    logic [dpp_pkg::PIX_W-1:0] red_reg;
    logic                      last_reg;
    logic [MAG_W-1:0]          magx_reg;
    logic [MAG_W-1:0]          magy_reg;
    logic                      negx_reg;
    logic                      negy_reg;

    logic [PZ_W-1:0]   pzx_reg;
    logic [PZ_W-1:0]   pzy_reg;
    logic [PROD_W-1:0] px_reg;
    logic [PROD_W-1:0] py_reg;

    dpp_pkg::pt_t pt_reg;
    dpp_pkg::pt_t pt_next;

    function automatic logic [SZ_W-1:0] eff_size(input logic [dpp_pkg::SIZE_W-1:0] v);
        logic [SZ_W-1:0] ve;
        ve = SZ_W'(v);
        if (v == '0)
            return SZ_W'(1);
        else if (ve > SZ_W'(MAX_DIM))
            return SZ_W'(MAX_DIM);
        else
            return ve;
    endfunction

    // round half away from zero on the magnitude, then restore sign and clamp
    function automatic logic [dpp_pkg::COORD_W-1:0] round_sat(
        input logic [PROD_W-1:0] p,
        input logic              neg
    );
        logic [PROD_W:0] r;
        r = ({1'b0, p} + HALF) >> SH;
        if (neg)
        begin
            if (r > LIM_NEG)
                return dpp_pkg::COORD_MIN;
            else
                return ~r[dpp_pkg::COORD_W-1:0] + dpp_pkg::COORD_W'(1);
        end
        else
        begin
            if (r > LIM_POS)
                return dpp_pkg::COORD_MAX;
            else
                return r[dpp_pkg::COORD_W-1:0];
        end
    endfunction

    assign width_eff   = eff_size(cfg.frame_width);
    assign height_eff  = eff_size(cfg.frame_height);
    assign end_row     = (SZ_W'(col_reg) + SZ_W'(1)) >= width_eff;
    assign end_col_row = (SZ_W'(row_reg) + SZ_W'(1)) >= height_eff;

    assign dx = OFF_W'({col_reg, 4'b0000}) - OFF_W'(cfg.center_x);
    assign dy = OFF_W'(cfg.center_y) - OFF_W'({row_reg, 4'b0000});

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.capture)
        begin
            if (end_row)
            begin
                col_next = '0;
                row_next = end_col_row ? '0 : row_reg + CNT_W'(1);
            end
            else
            begin
                col_next = col_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        pt_next = pt_reg;
        if (cmd.load_out)
        begin
            pt_next.point_x     = round_sat(px_reg, negx_reg);
            pt_next.point_y     = round_sat(py_reg, negy_reg);
            pt_next.point_z     = z_reg;
            pt_next.blue_out    = blue_reg;
            pt_next.green_out   = green_reg;
            pt_next.red_out     = red_reg;
            pt_next.point_valid = (z_reg != '0);
            pt_next.frame_last  = last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            z_reg     <= pix.depth;
            // colour only goes out for a valid depth with colour enabled
            blue_reg  <= (pix.depth != '0 && cfg.color_enable) ? pix.blue_in : '0;
            green_reg <= (pix.depth != '0 && cfg.color_enable) ? pix.green_in : '0;
            red_reg   <= (pix.depth != '0 && cfg.color_enable) ? pix.red_in : '0;
            last_reg  <= end_row && end_col_row;
            negx_reg  <= dx[OFF_W-1];
            negy_reg  <= dy[OFF_W-1];
            magx_reg  <= dx[OFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            magy_reg  <= dy[OFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        end
        if (cmd.mul_depth)
        begin
            pzx_reg <= PZ_W'(magx_reg) * PZ_W'(z_reg);
            pzy_reg <= PZ_W'(magy_reg) * PZ_W'(z_reg);
        end
        if (cmd.mul_focal)
        begin
            px_reg <= PROD_W'(pzx_reg) * PROD_W'(cfg.inv_focal_x);
            py_reg <= PROD_W'(pzy_reg) * PROD_W'(cfg.inv_focal_y);
        end
        pt_reg <= pt_next;
    end

    assign pt = pt_reg;

endmodule

`default_nettype wire

>>> src/depth_pixel_to_point.sv
// a pixel request is taken in the idle state; its point is then worked through the
// capture, depth multiply, focal multiply and round/saturate steps run by the
// controller in turn, and no new pixel is taken until that point is loaded out
// a held point keeps the next pixel in its saturate step until the output drains
// reset: asynchronous active low, clears the raster counters to the frame origin,
// empties the output and loads the default camera registers
`default_nettype none

module depth_pixel_to_point #(
    parameter int MAX_DIM       = 1024,
    parameter int OUT_FRAC_BITS = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        pix_valid,
    output logic                             pix_ready,
    input  wire dpp_pkg::pix_t               pix,
    output logic                             pt_valid,
    input  wire logic                        pt_ready,
    output dpp_pkg::pt_t                     pt,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [dpp_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [dpp_pkg::DATA_W-1:0]  pwdata,
    output logic      [dpp_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    dpp_pkg::cfg_t cfg;
    dpp_pkg::cmd_t cmd;

    dpp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pt_valid  (pt_valid),
        .pt_ready  (pt_ready),
        .cmd       (cmd)
    );

    dpp_datapath #(
        .MAX_DIM       (MAX_DIM),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (cmd),
        .pix   (pix),
        .pt    (pt)
    );

endmodule

`default_nettype wire
